// ----- design/ret_pkg.sv -----
// ret_pkg: types, codes and helper functions of the read extension tracker
// depends on nothing; imported by read_extension_tracker and tb_read_extension_tracker

package ret_pkg;

	localparam logic [1:0] ST_ASM  = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	localparam logic [1:0] KIND_MISS = 2'd0;
	localparam logic [1:0] KIND_LIVE = 2'd1;
	localparam logic [1:0] KIND_DEL  = 2'd2;

	localparam logic ACT_OPEN   = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [10:0] CNT_MAX = 11'h7FF;

	// one read's tracking record, kept in the state memory
	typedef struct packed {
		logic        strand;
		logic [10:0] first_pos;
		logic [10:0] last_pos;
		logic [10:0] last_hit_pos;
		logic [10:0] appear_total;
		logic [10:0] miss_total;
		logic [1:0]  miss_runs;
		logic        deleted;
		logic [1:0]  status;
	} state_t;

	function automatic logic [10:0] sat_add(logic [10:0] a, logic [10:0] b);
		logic [11:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[11] ? CNT_MAX : sum[10:0];
	endfunction

	// position the next lookup has to hit, clamped to 13 bits signed
	function automatic logic signed [12:0] exp_pos(state_t s);
		logic signed [13:0] lst;
		logic signed [13:0] fst;
		logic signed [13:0] span;
		logic signed [13:0] e;
		lst  = {3'b000, s.last_pos};
		fst  = {3'b000, s.first_pos};
		span = {3'b000, s.appear_total} + {3'b000, s.miss_total};
		if (s.last_pos != 11'd0) begin
			e = s.strand ? lst - 14'sd1 : lst + 14'sd1;
		end else begin
			e = s.strand ? fst - span : fst + span;
		end
		if (e < -14'sd4096) begin
			e = -14'sd4096;
		end else if (e > 14'sd4095) begin
			e = 14'sd4095;
		end
		return 13'(e);
	endfunction

	// status after an update; full and tail come from the read geometry
	function automatic logic [1:0] judge(state_t s, logic signed [13:0] full,
			logic signed [13:0] tail, logic [5:0] kmer);
		logic signed [13:0] fst;
		logic signed [13:0] lst;
		logic signed [13:0] lhit;
		logic signed [13:0] app;
		logic signed [13:0] span;
		logic signed [13:0] mis;
		logic signed [13:0] kk;
		logic signed [13:0] final_pos;
		logic [1:0]         st;
		fst  = {3'b000, s.first_pos};
		lst  = {3'b000, s.last_pos};
		lhit = {3'b000, s.last_hit_pos};
		app  = {3'b000, s.appear_total};
		mis  = {3'b000, s.miss_total};
		span = app + mis;
		kk   = {8'b0, kmer};
		final_pos = s.strand ? 14'sd1 : full;
		st = s.status;
		if (s.deleted || s.miss_runs > 2'd1) begin
			st = ST_FAIL;
		end else if (s.miss_runs == 2'd1) begin
			if (!s.strand && s.last_pos == 11'd0 && lhit >= tail) begin
				st = ST_OK;
			end else if (s.strand && fst != full) begin
				st = ST_FAIL;
			end else if (span == full) begin
				st = (lst == final_pos) ? ST_OK : ST_FAIL;
			end else if (s.last_pos != 11'd0 && mis != kk) begin
				st = ST_FAIL;
			end else if (s.last_pos == 11'd0 && mis > kk) begin
				st = ST_FAIL;
			end
		end else if (!s.strand) begin
			if (app == full) begin
				st = ST_OK;
			end
		end else begin
			if ((fst != full && s.last_pos == 11'd1) || (fst == full && app == full)) begin
				st = ST_OK;
			end
		end
		return st;
	endfunction

endpackage

// ----- design/read_extension_tracker.sv -----
// read_extension_tracker: top level, state memory with read-modify-write and forwarding
// depends on ret_pkg for the state record, codes and update functions
//
// Usage: an open beat (action 0) starts a read at a strand and position; each
// lookup beat (action 1) carries the outcome of the position search for the
// next k-mer. Every input beat yields exactly one result beat with the status,
// the position the next lookup must match, the hit count and the miss runs.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A result is registered: the state memory is read as its input beat is accepted,
// and the update lands in the output register as the beat leaves the update stage,
// which a stall of the receiver can hold back.
// Throughput: one beat per cycle while the receiver does not stall; the state
// memory is read as a beat enters and written as it leaves the update stage, and
// a forwarding register feeds the record just written to the beat behind it.
// Reset: the tracking record reads as all zero (assembling) until first written,
// configuration takes its reset values. When the receiver stalls, the result is
// held, one more beat waits in the update stage, and then in_stall is raised.
// Configuration is an APB-style port at byte addresses 0, 4, 8.

module read_extension_tracker
	import ret_pkg::*;
#(
	parameter int MAX_READ_LEN = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic               orientation,
	input  logic [10:0]        start_pos,
	input  logic [1:0]         match_kind,
	input  logic [10:0]        hit_pos,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [12:0] expected_pos,
	output logic [10:0]        hit_count,
	output logic [1:0]         miss_blocks
);

	localparam logic [1:0] REG_READ_LEN = 2'd0;
	localparam logic [1:0] REG_KMER     = 2'd1;
	localparam logic [1:0] REG_END3     = 2'd2;

	logic [10:0] read_len_q;
	logic [5:0]  kmer_len_q;
	logic [5:0]  end3_len_q;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_len_q <= 11'd36;
			kmer_len_q <= 6'd12;
			end3_len_q <= 6'd2;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_READ_LEN: read_len_q <= pwdata[10:0];
				REG_KMER:     kmer_len_q <= pwdata[5:0];
				REG_END3:     end3_len_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_READ_LEN: prdata = {21'b0, read_len_q};
			REG_KMER:     prdata = {26'b0, kmer_len_q};
			REG_END3:     prdata = {26'b0, end3_len_q};
			default:      prdata = 32'b0;
		endcase
	end

	// read geometry
	logic [10:0]        rl;
	logic signed [13:0] rl_s;
	logic signed [13:0] full;
	logic signed [13:0] tail;

	always_comb begin
		rl = read_len_q;
		if ({6'b0, read_len_q} > 17'(MAX_READ_LEN)) begin
			rl = 11'(MAX_READ_LEN);
		end
		rl_s = {3'b000, rl};
		full = rl_s - $signed({8'b0, kmer_len_q}) + 14'sd1;
		tail = full - $signed({8'b0, end3_len_q});
	end

	// pipeline control
	logic   vld_s1;
	logic   fwd_s1;
	logic   mem_vld_s1;
	logic   action_s1;
	logic   orient_s1;
	logic   [10:0] start_s1;
	logic   [1:0]  kind_s1;
	logic   [10:0] hpos_s1;
	logic   adv_s1;
	logic   accept;
	logic   init_q;
	logic   out_valid_q;
	state_t rd_data_s1;
	state_t wr_data_q;
	state_t cur;
	state_t nxt;
	state_t state_mem [1];

	assign adv_s1   = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = vld_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			fwd_s1      <= 1'b0;
			mem_vld_s1  <= 1'b0;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1     <= 1'b1;
				// a write at this same edge is not yet in the read data
				fwd_s1     <= adv_s1;
				mem_vld_s1 <= init_q;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				init_q      <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			orient_s1 <= orientation;
			start_s1  <= start_pos;
			kind_s1   <= match_kind;
			hpos_s1   <= hit_pos;
		end
	end

	// state memory, registered read
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			state_mem[0] <= nxt;
		end
		if (accept) begin
			rd_data_s1 <= state_mem[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			wr_data_q <= nxt;
		end
	end

	// update stage
	logic signed [12:0] cur_exp;
	logic               at_place;

	always_comb begin
		if (fwd_s1) begin
			cur = wr_data_q;
		end else if (mem_vld_s1) begin
			cur = rd_data_s1;
		end else begin
			cur = '0;
		end
		cur_exp  = exp_pos(cur);
		at_place = (hpos_s1 != 11'd0) && ($signed({2'b00, hpos_s1}) == cur_exp);
		nxt = cur;
		if (action_s1 == ACT_OPEN) begin
			nxt.strand       = orient_s1;
			nxt.first_pos    = start_s1;
			nxt.last_pos     = start_s1;
			nxt.last_hit_pos = start_s1;
			nxt.appear_total = 11'd1;
			nxt.miss_total   = 11'd0;
			nxt.miss_runs    = 2'd0;
			nxt.deleted      = 1'b0;
			nxt.status       = ST_ASM;
			nxt.status       = judge(nxt, full, tail, kmer_len_q);
		end else if (cur.status == ST_ASM) begin
			if (kind_s1 == KIND_LIVE && at_place) begin
				nxt.appear_total = sat_add(cur.appear_total, 11'd1);
				nxt.last_pos     = hpos_s1;
				nxt.last_hit_pos = hpos_s1;
			end else if (kind_s1 == KIND_DEL && at_place) begin
				nxt.deleted = 1'b1;
			end else if (cur.last_pos != 11'd0) begin
				// a new miss run starts
				nxt.appear_total = sat_add(cur.appear_total, cur.miss_total);
				nxt.miss_total   = 11'd1;
				nxt.last_pos     = 11'd0;
				if (cur.miss_runs < 2'd2) begin
					nxt.miss_runs = cur.miss_runs + 2'd1;
				end
			end else begin
				nxt.miss_total = sat_add(cur.miss_total, 11'd1);
			end
			nxt.status = judge(nxt, full, tail, kmer_len_q);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status       <= nxt.status;
			expected_pos <= exp_pos(nxt);
			hit_count    <= nxt.appear_total;
			miss_blocks  <= nxt.miss_runs;
		end
	end

	assign out_valid = out_valid_q;

	// a finished read ignores lookups
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && action_s1 == ACT_LOOKUP && cur.status != ST_ASM) |-> (nxt == cur))
		else $error("finished read changed state");

	// an open beat leaves a fresh record behind
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && action_s1 == ACT_OPEN) |=>
			(wr_data_q.appear_total == 11'd1 && wr_data_q.first_pos == $past(start_s1)
			&& hit_count == 11'd1))
		else $error("open beat did not reset the record");

	// forwarding only ever applies once a record has been written
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && fwd_s1) |-> init_q)
		else $error("forwarded record before any write");

	a_runs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (miss_blocks != 2'd3 && status != 2'd3))
		else $error("result code out of range");

endmodule

// ----- bench/tb_read_extension_tracker.sv -----
// tb_read_extension_tracker: self-checking bench for the read extension tracker
// predicts every result beat from the accepted input beats and compares field by field
// depends on ret_pkg and read_extension_tracker from the design folder

module tb_read_extension_tracker
	import ret_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int READ_LEN_CAP = 1024;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 8;

	localparam logic [3:0] ADDR_READ_LEN = 4'd0;
	localparam logic [3:0] ADDR_KMER     = 4'd4;
	localparam logic [3:0] ADDR_END3     = 4'd8;

	// lookup code the search never sends, still has to count as a miss
	localparam logic [1:0] KIND_BAD = 2'd3;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [12:0] epos;
		logic [10:0]        hits;
		logic [1:0]         blocks;
	} read_report_t;

	class extension_scoreboard;
		logic [10:0] read_len = 11'd36;
		logic [5:0]  kmer_len = 6'd12;
		logic [5:0]  end3_len = 6'd2;
		logic        strand;
		logic [10:0] first_pos;
		logic [10:0] last_pos;
		logic [10:0] last_hit;
		logic [10:0] appear;
		logic [10:0] misses;
		logic [1:0]  runs;
		logic        deleted;
		logic [1:0]  status;
		read_report_t status_reports[$];
		int          errors;

		function new();
			strand = 1'b0;
			first_pos = '0;
			last_pos = '0;
			last_hit = '0;
			appear = '0;
			misses = '0;
			runs = '0;
			deleted = 1'b0;
			status = ST_ASM;
			errors = 0;
		endfunction

		function int pending();
			return status_reports.size();
		endfunction

		function logic [10:0] sat11(int v);
			return (v > 2047) ? CNT_MAX : 11'(v);
		endfunction

		// position the next lookup has to hit
		function int next_pos();
			int e;
			int span;
			span = int'(appear) + int'(misses);
			if (last_pos != 0) begin
				e = strand ? int'(last_pos) - 1 : int'(last_pos) + 1;
			end else begin
				e = strand ? int'(first_pos) - span : int'(first_pos) + span;
			end
			if (e < -4096) begin
				e = -4096;
			end
			if (e > 4095) begin
				e = 4095;
			end
			return e;
		endfunction

		function void take_miss();
			if (last_pos != 0) begin
				appear = sat11(int'(appear) + int'(misses));
				misses = 11'd1;
				last_pos = '0;
				if (runs < 2) begin
					runs++;
				end
			end else begin
				misses = sat11(int'(misses) + 1);
			end
		endfunction

		function void grade_read();
			int rl;
			int full;
			int tail;
			int fst;
			int lst;
			int lhit;
			int app;
			int mis;
			int k;
			rl = (read_len > 11'd1024) ? READ_LEN_CAP : int'(read_len);
			full = rl - int'(kmer_len) + 1;
			tail = full - int'(end3_len);
			fst = int'(first_pos);
			lst = int'(last_pos);
			lhit = int'(last_hit);
			app = int'(appear);
			mis = int'(misses);
			k = int'(kmer_len);
			if (deleted || runs > 2'd1) begin
				status = ST_FAIL;
			end else if (runs == 2'd1) begin
				if (!strand && lst == 0 && lhit >= tail) begin
					status = ST_OK;
				end else if (strand && fst != full) begin
					status = ST_FAIL;
				end else if (app + mis == full) begin
					status = (lst == (strand ? 1 : full)) ? ST_OK : ST_FAIL;
				end else if (lst > 0 && mis != k) begin
					status = ST_FAIL;
				end else if (lst == 0 && mis > k) begin
					status = ST_FAIL;
				end
			end else if (!strand) begin
				if (app == full) begin
					status = ST_OK;
				end
			end else if ((fst != full && lst == 1) || (fst == full && app == full)) begin
				status = ST_OK;
			end
		endfunction

		// update the tracked read with one accepted input beat
		function void take_beat(logic act, logic ori, logic [10:0] sp, logic [1:0] kind,
				logic [10:0] hp);
			read_report_t r;
			logic at_place;
			at_place = (hp != 0) && (int'(hp) == next_pos());
			if (act == ACT_OPEN) begin
				strand = ori;
				first_pos = sp;
				last_pos = sp;
				last_hit = sp;
				appear = 11'd1;
				misses = '0;
				runs = '0;
				deleted = 1'b0;
				status = ST_ASM;
				grade_read();
			end else if (status == ST_ASM) begin
				if (kind == KIND_LIVE && at_place) begin
					appear = sat11(int'(appear) + 1);
					last_pos = hp;
					last_hit = hp;
				end else if (kind == KIND_DEL && at_place) begin
					deleted = 1'b1;
				end else begin
					take_miss();
				end
				grade_read();
			end
			r.status = status;
			r.epos = 13'(next_pos());
			r.hits = appear;
			r.blocks = runs;
			status_reports.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) begin
				$display("ERROR at %0t: %s", $time, msg);
			end
		endtask

		task compare_result(logic [1:0] st, logic signed [12:0] ep, logic [10:0] hc,
				logic [1:0] mb);
			read_report_t e;
			if (status_reports.size() == 0) begin
				report("result beat with no prediction waiting");
			end else begin
				e = status_reports.pop_front();
				if (st !== e.status) begin
					report($sformatf("status %0d, predicted %0d", st, e.status));
				end
				if (ep !== e.epos) begin
					report($sformatf("expected_pos %0d, predicted %0d", ep, e.epos));
				end
				if (hc !== e.hits) begin
					report($sformatf("hit_count %0d, predicted %0d", hc, e.hits));
				end
				if (mb !== e.blocks) begin
					report($sformatf("miss_blocks %0d, predicted %0d", mb, e.blocks));
				end
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               action;
	logic               orientation;
	logic [10:0]        start_pos;
	logic [1:0]         match_kind;
	logic [10:0]        hit_pos;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic signed [12:0] expected_pos;
	logic [10:0]        hit_count;
	logic [1:0]         miss_blocks;

	extension_scoreboard sb;
	int unsigned cycles = 0;
	int  burst_left = 0;
	bit  idle_on = 1'b1;
	bit  stall_on = 1'b1;
	bit  stalling = 1'b0;
	int  stall_run = 0;

	int phase_len[PHASES]   = '{36, 2, 16, 1024, 2047, 40, 10, 64};
	int phase_kmer[PHASES]  = '{12, 1, 5, 63, 1, 8, 20, 16};
	int phase_end3[PHASES]  = '{2, 0, 0, 63, 0, 63, 3, 6};
	int phase_items[PHASES] = '{500, 150, 250, 150, 100, 250, 150, 300};

	read_extension_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.orientation(orientation),
		.start_pos(start_pos),
		.match_kind(match_kind),
		.hit_pos(hit_pos),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.expected_pos(expected_pos),
		.hit_count(hit_count),
		.miss_blocks(miss_blocks)
	);

	always #2 clk = ~clk;

	// receiver: free and stalled runs of random length; a stalled run is always followed by a free one
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stalling = stall_on && !stalling && ($urandom_range(0, 2) != 0);
			stall_run = stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
			if (stalling && $urandom_range(0, 15) == 0) begin
				stall_run = 24;
			end
		end else begin
			stall_run--;
		end
		out_stall = stalling;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			sb.compare_result(status, expected_pos, hit_count, miss_blocks);
		end
	end

	// one input beat; the sender may idle between bursts
	task send(input logic act, input logic ori, input logic [10:0] sp, input logic [1:0] kind,
			input logic [10:0] hp);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			repeat (idle_on ? $urandom_range(0, 6) : 0) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
		@(negedge clk);
		in_valid = 1'b1;
		action = act;
		orientation = ori;
		start_pos = sp;
		match_kind = kind;
		hit_pos = hp;
		do @(posedge clk); while (in_stall);
		sb.take_beat(act, ori, sp, kind, hp);
		burst_left--;
	endtask

	task hit_next(input logic [1:0] kind);
		send(ACT_LOOKUP, 1'($urandom), 11'($urandom), kind, 11'(sb.next_pos()));
	endtask

	task wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task write_reg(input logic [3:0] addr, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task set_config(input logic [10:0] rl, input logic [5:0] k, input logic [5:0] e3);
		wait_idle();
		write_reg(ADDR_READ_LEN, 32'(rl));
		sb.read_len = rl;
		write_reg(ADDR_KMER, 32'(k));
		sb.kmer_len = k;
		write_reg(ADDR_END3, 32'(e3));
		sb.end3_len = e3;
	endtask

	initial begin
		int sent;
		int used;
		int miss_left;
		int rl;
		int full;
		int ori;
		int start;
		int roll;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		action = ACT_OPEN;
		orientation = 1'b0;
		start_pos = '0;
		match_kind = KIND_MISS;
		hit_pos = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: lookups before any open, zero position, unused code
		send(ACT_LOOKUP, 1'b0, 11'h7FF, KIND_LIVE, 11'd0);
		send(ACT_LOOKUP, 1'b1, 11'd0, KIND_BAD, 11'h7FF);
		// plus read: hit, hit at the wrong place, deleted entry, then frozen
		send(ACT_OPEN, 1'b0, 11'd1, KIND_MISS, 11'd0);
		hit_next(KIND_LIVE);
		send(ACT_LOOKUP, 1'b0, 11'd0, KIND_LIVE, 11'd5);
		hit_next(KIND_DEL);
		hit_next(KIND_LIVE);
		// minus reads at the top position and down to position one
		send(ACT_OPEN, 1'b1, 11'd1024, KIND_MISS, 11'd0);
		hit_next(KIND_LIVE);
		send(ACT_OPEN, 1'b1, 11'd2, KIND_MISS, 11'd0);
		hit_next(KIND_LIVE);
		// plus read already at the 3-prime tail, then a miss
		send(ACT_OPEN, 1'b0, 11'd23, KIND_MISS, 11'd0);
		send(ACT_LOOKUP, 1'b0, 11'd0, KIND_MISS, 11'd24);
		// read length above the cap, widest k-mer and tail
		set_config(11'd2047, 6'd63, 6'd63);
		send(ACT_OPEN, 1'b1, 11'd962, KIND_MISS, 11'd0);
		hit_next(KIND_LIVE);
		send(ACT_OPEN, 1'b0, 11'd1, KIND_MISS, 11'd0);
		// shortest read
		set_config(11'd2, 6'd1, 6'd0);
		send(ACT_OPEN, 1'b0, 11'd1, KIND_MISS, 11'd0);
		hit_next(KIND_LIVE);
		send(ACT_OPEN, 1'b1, 11'd2, KIND_MISS, 11'd0);
		hit_next(KIND_LIVE);
		send(ACT_OPEN, 1'b1, 11'd1, KIND_MISS, 11'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_config(11'(phase_len[ph]), 6'(phase_kmer[ph]), 6'(phase_end3[ph]));
			idle_on = (ph % 4 == 0) || (ph % 4 == 1);
			stall_on = (ph % 4 == 0) || (ph % 4 == 2);
			sent = 0;
			while (sent < phase_items[ph]) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					// noise beat, any field value
					send(1'($urandom), 1'($urandom), 11'($urandom), 2'($urandom), 11'($urandom));
					sent++;
				end else begin
					rl = (sb.read_len > 11'd1024) ? READ_LEN_CAP : int'(sb.read_len);
					full = rl - int'(sb.kmer_len) + 1;
					ori = $urandom_range(0, 1);
					if (full < 1) begin
						start = $urandom_range(1, 1024);
					end else if ($urandom_range(0, 3) != 0) begin
						start = ori ? full : 1;
					end else begin
						start = $urandom_range(1, full);
					end
					send(ACT_OPEN, ori[0], 11'(start), 2'($urandom), 11'($urandom));
					sent++;
					used = 1;
					miss_left = 0;
					while (sent < phase_items[ph] && used < (full > 0 ? full : 0) + 64 &&
							sb.status == ST_ASM) begin
						if (miss_left > 0) begin
							send(ACT_LOOKUP, 1'($urandom), 11'($urandom), KIND_MISS,
									11'($urandom));
							miss_left--;
							sent++;
							used++;
						end else begin
							roll = $urandom_range(0, 99);
							if (roll >= 84 && roll < 90) begin
								// a run of exactly k misses keeps the read alive
								miss_left = $urandom_range(0, 1) ? int'(sb.kmer_len) :
										$urandom_range(1, int'(sb.kmer_len) + 3);
							end else begin
								if (roll < 84) begin
									hit_next(KIND_LIVE);
								end else if (roll < 93) begin
									hit_next(KIND_DEL);
								end else if (roll < 97) begin
									send(ACT_LOOKUP, 1'($urandom), 11'($urandom), KIND_LIVE,
											$urandom_range(0, 1) ? 11'd0 :
											11'(sb.next_pos() + $urandom_range(1, 3)));
								end else begin
									send(ACT_LOOKUP, 1'($urandom), 11'($urandom), KIND_BAD,
											11'($urandom));
								end
								sent++;
								used++;
							end
						end
					end
					// lookup on a finished read
					if (sent < phase_items[ph] && $urandom_range(0, 3) == 0) begin
						hit_next(2'($urandom_range(0, 2)));
						sent++;
					end
				end
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
